// ----- rtl/core/urs_pkg.sv -----
// Shared constants for the ultrasonic ranging sequencer: register indexes,
// reset values, status codes and the widths of the distance divider.
// No dependencies.
package urs_pkg;

   localparam int COUNT_WIDTH_DEF = 17;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int TRIG_W   = 10;
   localparam int TMO_W    = 16;
   localparam int FACTOR_W = 8;
   localparam int STATUS_W = 2;
   localparam int WIDTH_W  = 16;
   localparam int DIST_W   = 24;
   localparam int FRAC_W   = 8;

   // dividend = (width << 8) + (factor << 7)
   localparam int DVD_W = WIDTH_W + FRAC_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_TIMEOUT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONV_FACTOR   = 2'd3;

   localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RST = 10'd10;
   localparam logic [TMO_W-1:0]    START_TIMEOUT_RST = 16'd5000;
   localparam logic [TMO_W-1:0]    ECHO_TIMEOUT_RST  = 16'd60000;
   localparam logic [FACTOR_W-1:0] CONV_FACTOR_RST   = 8'd57;

   localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_OBJ   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FIRE  = 2'd2;

endpackage

// ----- rtl/core/urs_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, for the distance.
// Depends on urs_pkg for the dividend and divisor widths.
module urs_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [urs_pkg::DVD_W-1:0]             dividend,
   input  logic [urs_pkg::FACTOR_W-1:0]          divisor,
   output logic                                  busy,
   output logic [urs_pkg::DIST_W-1:0]            quotient
);

   localparam int DVD_W  = urs_pkg::DVD_W;
   localparam int DIV_W  = urs_pkg::FACTOR_W;
   localparam int STEP_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff[urs_pkg::DIST_W-1:0];

endmodule

// ----- rtl/core/ultrasonic_ranging_sequencer_unit.sv -----
// Top level of the ultrasonic ranging sequencer: tick sequencer, config
// registers and result register. Depends on urs_pkg and urs_div.
//
// Usage: each transfer on the req_ channel is one microsecond tick with the
// sampled echo level; each tick yields exactly one transfer on the rsp_
// channel carrying the trigger drive level, a done flag, a status code, the
// echo width and the distance in centimetres (Q16.8).
// Flow: a tick that does not end an echo gives its result on the cycle
// after its transfer, and the next tick is taken in that same cycle, so one
// tick per cycle is sustained while rsp_ready is high. A tick that ends a
// valid echo starts the restoring divider (one quotient bit per cycle, 25
// bits); req_ready is low until the divider is done and its result is
// registered. The result register holds a result until rsp_ready takes it;
// a new tick is taken while the register drains in the same cycle.
// Reset: synchronous, active high; registers return to their defaults
// (trigger 10, start timeout 5000, echo timeout 60000, factor 57) and the
// sequencer restarts with a trigger pulse. csr_ writes take effect at once;
// the user must make them only while no tick is in flight (unchecked here).
module ultrasonic_ranging_sequencer_unit #(
   parameter int COUNT_WIDTH = urs_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_echo_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_trigger_out,
   output logic                              rsp_done_res,
   output logic [urs_pkg::STATUS_W-1:0]      rsp_status,
   output logic [urs_pkg::WIDTH_W-1:0]       rsp_echo_width,
   output logic [urs_pkg::DIST_W-1:0]        rsp_distance_q8,
   input  logic                              csr_we,
   input  logic [urs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [urs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW    = COUNT_WIDTH;
   localparam int CMP_W = (CW > urs_pkg::TMO_W) ? CW : urs_pkg::TMO_W;
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

   typedef logic [CMP_W-1:0] cmp_type;

   typedef enum logic [1:0] {
      PH_TRIG = 2'd0,
      PH_WAIT = 2'd1,
      PH_ECHO = 2'd2
   } phase_type;

   typedef enum logic {
      S_IDLE,
      S_DIV
   } state_type;

   logic [urs_pkg::TRIG_W-1:0]   trig_ticks_ff;
   logic [urs_pkg::TMO_W-1:0]    start_tmo_ff;
   logic [urs_pkg::TMO_W-1:0]    echo_tmo_ff;
   logic [urs_pkg::FACTOR_W-1:0] factor_ff;

   state_type                    state_ff, state_in;
   phase_type                    phase_ff, phase_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [urs_pkg::WIDTH_W-1:0]  hold_width_ff, hold_width_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_trig_ff, rsp_trig_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic [urs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [urs_pkg::WIDTH_W-1:0]  rsp_width_ff, rsp_width_in;
   logic [urs_pkg::DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic                         accept;
   logic                         out_free;
   logic [CW-1:0]                cnt_inc;
   logic                         cnt_inc_max;
   cmp_type                      cnt_ext;
   cmp_type                      cnt_inc_ext;
   cmp_type                      trig_lim;
   cmp_type                      start_lim;
   cmp_type                      echo_lim;
   logic [urs_pkg::FACTOR_W-1:0] factor_eff;

   phase_type                    step_phase;
   logic [CW-1:0]                step_cnt;
   logic                         step_trig;
   logic                         step_done;
   logic [urs_pkg::STATUS_W-1:0] step_status;
   logic [urs_pkg::WIDTH_W-1:0]  step_width;
   logic                         step_div;

   logic                         div_start;
   logic                         div_busy;
   logic [urs_pkg::DVD_W-1:0]    div_dividend;
   logic [urs_pkg::DIST_W-1:0]   div_quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff <= urs_pkg::TRIGGER_TICKS_RST;
         start_tmo_ff  <= urs_pkg::START_TIMEOUT_RST;
         echo_tmo_ff   <= urs_pkg::ECHO_TIMEOUT_RST;
         factor_ff     <= urs_pkg::CONV_FACTOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            urs_pkg::CSR_TRIGGER_TICKS: trig_ticks_ff <= csr_wdata[urs_pkg::TRIG_W-1:0];
            urs_pkg::CSR_START_TIMEOUT: start_tmo_ff  <= csr_wdata[urs_pkg::TMO_W-1:0];
            urs_pkg::CSR_ECHO_TIMEOUT:  echo_tmo_ff   <= csr_wdata[urs_pkg::TMO_W-1:0];
            urs_pkg::CSR_CONV_FACTOR:   factor_ff     <= csr_wdata[urs_pkg::FACTOR_W-1:0];
         endcase
      end
   end

   // zero-valued limits and conversion factor act as one
   always_comb begin
      trig_lim   = (trig_ticks_ff == '0) ? cmp_type'(1) : cmp_type'(trig_ticks_ff);
      start_lim  = (start_tmo_ff == '0)  ? cmp_type'(1) : cmp_type'(start_tmo_ff);
      echo_lim   = (echo_tmo_ff == '0)   ? cmp_type'(1) : cmp_type'(echo_tmo_ff);
      factor_eff = (factor_ff == '0) ? urs_pkg::FACTOR_W'(1) : factor_ff;
   end

   always_comb begin
      cnt_inc_max = (cnt_ff == CNT_MAX);
      cnt_inc     = cnt_inc_max ? cnt_ff : cnt_ff + 1'b1;
      cnt_ext     = cmp_type'(cnt_ff);
      cnt_inc_ext = cmp_type'(cnt_inc);
   end

   // one tick of the ranging sequence
   always_comb begin
      step_phase  = phase_ff;
      step_cnt    = cnt_ff;
      step_trig   = 1'b0;
      step_done   = 1'b0;
      step_status = urs_pkg::ST_VALID;
      step_width  = '0;
      step_div    = 1'b0;
      unique case (phase_ff)
         PH_WAIT: begin
            if (req_echo_level) begin
               if (echo_lim <= cmp_type'(1)) begin
                  step_done   = 1'b1;
                  step_status = urs_pkg::ST_NO_OBJ;
                  step_width  = urs_pkg::WIDTH_W'(1);
                  step_phase  = PH_TRIG;
                  step_cnt    = '0;
               end else begin
                  step_phase = PH_ECHO;
                  step_cnt   = CW'(1);
               end
            end else begin
               step_cnt = cnt_inc;
               if (cnt_inc_ext >= start_lim || cnt_inc == CNT_MAX) begin
                  step_done   = 1'b1;
                  step_status = urs_pkg::ST_NO_FIRE;
                  step_phase  = PH_TRIG;
                  step_cnt    = '0;
               end
            end
         end
         PH_ECHO: begin
            if (!req_echo_level) begin
               step_done  = 1'b1;
               step_width = cnt_ext[urs_pkg::WIDTH_W-1:0];
               step_div   = 1'b1;
               step_phase = PH_TRIG;
               step_cnt   = '0;
            end else begin
               step_cnt = cnt_inc;
               if (cnt_inc_ext >= echo_lim || cnt_inc == CNT_MAX) begin
                  step_done   = 1'b1;
                  step_status = urs_pkg::ST_NO_OBJ;
                  step_width  = cnt_inc_ext[urs_pkg::WIDTH_W-1:0];
                  step_phase  = PH_TRIG;
                  step_cnt    = '0;
               end
            end
         end
         default: begin
            step_trig = 1'b1;
            step_cnt  = cnt_inc;
            if (cnt_inc_ext >= trig_lim || cnt_inc == CNT_MAX) begin
               step_phase = PH_WAIT;
               step_cnt   = '0;
            end
         end
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign div_dividend = {1'b0, step_width, {urs_pkg::FRAC_W{1'b0}}}
                       + {{(urs_pkg::DVD_W - urs_pkg::FACTOR_W - urs_pkg::FRAC_W + 1){1'b0}},
                          factor_eff, {(urs_pkg::FRAC_W - 1){1'b0}}};
   assign div_start    = accept && step_div;

   urs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (factor_eff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      hold_width_in = hold_width_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_trig_in   = rsp_trig_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_dist_in   = rsp_dist_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               phase_in = step_phase;
               cnt_in   = step_cnt;
               if (step_div) begin
                  state_in      = S_DIV;
                  hold_width_in = step_width;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_trig_in   = step_trig;
                  rsp_done_in   = step_done;
                  rsp_status_in = step_status;
                  rsp_width_in  = step_width;
                  rsp_dist_in   = '0;
               end
            end
         end
         S_DIV: begin
            if (!div_busy && out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_trig_in   = 1'b0;
               rsp_done_in   = 1'b1;
               rsp_status_in = urs_pkg::ST_VALID;
               rsp_width_in  = hold_width_ff;
               rsp_dist_in   = div_quotient;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_TRIG;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_width_ff <= hold_width_in;
      rsp_trig_ff   <= rsp_trig_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trigger_out = rsp_trig_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_echo_width  = rsp_width_ff;
   assign rsp_distance_q8 = rsp_dist_ff;

endmodule
